### rtl/dpfh_pkg.sv
// ----------------------------------------------------------------------------
// dpfh_pkg
// Shared types, constants and helper function for the dew point pipeline.
// ----------------------------------------------------------------------------
package dpfh_pkg;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic        [13:0] humidity_centi;
    } t_in;

    typedef struct packed {
        logic signed [14:0] dew_point_centi;
        logic               valid_res;
    } t_out;

    localparam logic [13:0]        RH_FULL = 14'd10000;
    localparam logic signed [16:0] B_CENTI = 17'sd24304;
    // 2 * (141 * 8192): numerator of the temperature term, doubled for rounding
    localparam logic signed [38:0] T_NUM2  = 39'sd2310144;
    localparam logic signed [24:0] A_Q16   = 25'sd1155072;
    localparam logic signed [39:0] B_MUL   = 40'sd24304;
    localparam logic signed [30:0] LN2_Q30 = 31'sd744261118;
    localparam logic signed [51:0] HALF_Q30 = 52'sd536870912;
    localparam logic signed [14:0] TD_MIN  = -15'sd11000;
    localparam logic signed [14:0] TD_MAX  = 15'sd8500;

    // log2 squaring rounds and output format
    localparam int LG_ROUNDS = 16;
    localparam int LN_W      = 21;

    // temperature-term divider
    localparam int T_AW = 36;
    localparam int T_DW = 17;
    localparam int T_QW = 22;

    // dew point divider
    localparam int D_AW = 38;
    localparam int D_DW = 24;
    localparam int D_QW = 16;

    localparam int LOG_LAT = LG_ROUNDS + 3;
    localparam int LATENCY = 2 + (T_QW + 1) + LOG_LAT + 2 + (D_QW + 1) + 1;

    // Q16 binary log by repeated squaring, evaluated at elaboration only
    function automatic logic [19:0] f_log2_q16(input logic [13:0] x);
        logic [3:0]  top;
        logic [30:0] m;
        logic [61:0] p;
        logic [15:0] f;
        top = '0;
        f   = '0;
        for (int i = 0; i < 14; i++) begin
            if (x[i]) begin
                top = 4'(i);
            end
        end
        m = 31'(x) << (5'd30 - {1'b0, top});
        for (int i = 0; i < LG_ROUNDS; i++) begin
            p = 62'(m) * 62'(m);
            if (p[61]) begin
                m = p[61:31];
                f[15 - i] = 1'b1;
            end else begin
                m = p[60:30];
            end
        end
        return {top, f};
    endfunction

    localparam logic [19:0] LG_FULL = f_log2_q16(RH_FULL);

endpackage

### rtl/dpfh_div.sv
// ----------------------------------------------------------------------------
// dpfh_div
// Pipelined restoring divider, one quotient bit per stage, sign applied last.
// ----------------------------------------------------------------------------
module dpfh_div #(
    parameter int AW = 36,
    parameter int DW = 17,
    parameter int QW = 22,
    parameter int PW = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [AW-1:0]        i_a,
    input  logic [DW-1:0]        i_d,
    input  logic                 i_neg,
    input  logic [PW-1:0]        i_pl,
    output logic                 o_valid,
    output logic signed [QW:0]   o_q,
    output logic [PW-1:0]        o_pl
);

    logic            r_v   [QW];
    logic [DW-1:0]   r_rem [QW];
    logic [QW-1:0]   r_aq  [QW];
    logic [DW-1:0]   r_d   [QW];
    logic            r_neg [QW];
    logic [PW-1:0]   r_pl  [QW];

    logic                r_fv;
    logic signed [QW:0]  r_q;
    logic [PW-1:0]       r_fpl;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          w_v;
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_aq;
        logic [DW-1:0] w_d;
        logic          w_neg;
        logic [PW-1:0] w_pl;
        logic [DW:0]   w_t;
        logic [DW:0]   w_sub;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_aq;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = DW'(i_a[AW-1:QW]);
            assign w_aq  = i_a[QW-1:0];
            assign w_d   = i_d;
            assign w_neg = i_neg;
            assign w_pl  = i_pl;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_rem = r_rem[k-1];
            assign w_aq  = r_aq[k-1];
            assign w_d   = r_d[k-1];
            assign w_neg = r_neg[k-1];
            assign w_pl  = r_pl[k-1];
        end

        assign w_t   = {w_rem, w_aq[QW-1]};
        assign w_ge  = (w_t >= {1'b0, w_d});
        assign w_sub = w_t - {1'b0, w_d};
        assign n_rem = w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
        assign n_aq  = {w_aq[QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_aq[k]  <= n_aq;
            r_d[k]   <= w_d;
            r_neg[k] <= w_neg;
            r_pl[k]  <= w_pl;
        end
    end

    logic signed [QW:0] w_mag;
    logic signed [QW:0] n_q;

    assign w_mag = $signed({1'b0, r_aq[QW-1]});
    assign n_q   = r_neg[QW-1] ? -w_mag : w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= r_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_fpl <= r_pl[QW-1];
    end

    assign o_valid = r_fv;
    assign o_q     = r_q;
    assign o_pl    = r_fpl;

endmodule

### rtl/dpfh_log2.sv
// ----------------------------------------------------------------------------
// dpfh_log2
// Pipelined natural log of RH relative to full scale, Q16, via binary log.
// ----------------------------------------------------------------------------
module dpfh_log2 #(
    parameter int PW = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [13:0]                         i_x,
    input  logic [PW-1:0]                       i_pl,
    output logic                                o_valid,
    output logic signed [dpfh_pkg::LN_W-1:0]    o_ln,
    output logic [PW-1:0]                       o_pl
);

    localparam int NR = dpfh_pkg::LG_ROUNDS;

    // normalize
    logic [3:0]    n_top;
    logic [30:0]   n_m0;
    logic          r_v0;
    logic [3:0]    r_top0;
    logic [30:0]   r_m0;
    logic [PW-1:0] r_pl0;

    always_comb begin
        n_top = '0;
        for (int i = 0; i < 14; i++) begin
            if (i_x[i]) begin
                n_top = 4'(i);
            end
        end
        n_m0 = 31'(i_x) << (5'd30 - {1'b0, n_top});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top0 <= n_top;
        r_m0   <= n_m0;
        r_pl0  <= i_pl;
    end

    // squaring rounds
    logic          r_v   [NR];
    logic [3:0]    r_top [NR];
    logic [30:0]   r_m   [NR];
    logic [15:0]   r_f   [NR];
    logic [PW-1:0] r_pl  [NR];

    for (genvar k = 0; k < NR; k++) begin : g_round
        logic          w_v;
        logic [3:0]    w_top;
        logic [30:0]   w_m;
        logic [15:0]   w_f;
        logic [PW-1:0] w_pl;
        logic [61:0]   w_p;
        logic [30:0]   n_m;
        logic [15:0]   n_f;

        if (k == 0) begin : g_first
            assign w_v   = r_v0;
            assign w_top = r_top0;
            assign w_m   = r_m0;
            assign w_f   = '0;
            assign w_pl  = r_pl0;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_top = r_top[k-1];
            assign w_m   = r_m[k-1];
            assign w_f   = r_f[k-1];
            assign w_pl  = r_pl[k-1];
        end

        assign w_p = 62'(w_m) * 62'(w_m);
        assign n_m = w_p[61] ? w_p[61:31] : w_p[60:30];
        assign n_f = {w_f[14:0], w_p[61]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_top[k] <= w_top;
            r_m[k]   <= n_m;
            r_f[k]   <= n_f;
            r_pl[k]  <= w_pl;
        end
    end

    // scale by ln 2
    logic signed [20:0] w_diff;
    logic signed [51:0] n_prod;
    logic               r_vm;
    logic signed [51:0] r_prod;
    logic [PW-1:0]      r_plm;

    assign w_diff = $signed({1'b0, r_top[NR-1], r_f[NR-1]})
                  - $signed({1'b0, dpfh_pkg::LG_FULL});
    assign n_prod = 52'(w_diff) * 52'(dpfh_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= r_v[NR-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_plm  <= r_pl[NR-1];
    end

    // round to Q16
    logic signed [51:0]                  w_sum;
    logic                                r_vr;
    logic signed [dpfh_pkg::LN_W-1:0]    r_ln;
    logic [PW-1:0]                       r_plr;

    assign w_sum = r_prod + dpfh_pkg::HALF_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else begin
            r_vr <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ln  <= w_sum[30 +: dpfh_pkg::LN_W];
        r_plr <= r_plm;
    end

    assign o_valid = r_vr;
    assign o_ln    = r_ln;
    assign o_pl    = r_plr;

endmodule

### rtl/dew_point_from_humidity.sv
// ----------------------------------------------------------------------------
// dew_point_from_humidity
// Magnus dew point from air temperature and relative humidity, fixed point.
// ----------------------------------------------------------------------------
// Takes one word per clock (busy never rises) and gives its result word on
// o_strobe in input order. The latency is set by the two bit-per-stage
// dividers (22 stages for a*T/(b+T), 16 for b*L/(a-L)) and the 16 squaring
// stages of the binary log. Zero humidity gives valid_res = 0 and the lowest
// dew point; humidity above 100 % is taken as 100 %.
// ----------------------------------------------------------------------------
module dew_point_from_humidity (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  dpfh_pkg::t_in    i_in,
    output logic             o_strobe,
    output dpfh_pkg::t_out   o_out
);

    localparam int T_QW = dpfh_pkg::T_QW;
    localparam int D_QW = dpfh_pkg::D_QW;

    assign o_busy = 1'b0;

    // input register with humidity saturation
    logic               r_v1;
    logic signed [14:0] r_tc;
    logic [13:0]        r_rh;
    logic               r_zero1;
    logic [13:0]        n_rh;

    assign n_rh = (i_in.humidity_centi > dpfh_pkg::RH_FULL) ? dpfh_pkg::RH_FULL
                                                              : i_in.humidity_centi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start & ~o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tc    <= i_in.temperature_centi;
        r_rh    <= n_rh;
        r_zero1 <= (i_in.humidity_centi == 14'd0);
    end

    // temperature term operands: floor((2n + d) / 2d)
    logic signed [16:0] w_den;
    logic [16:0]        w_dt2;
    logic signed [38:0] w_num;
    logic               w_tneg;
    logic [38:0]        w_tmag;

    assign w_den  = 17'(r_tc) + dpfh_pkg::B_CENTI;
    assign w_dt2  = {w_den[15:0], 1'b0};
    assign w_num  = 39'(r_tc) * dpfh_pkg::T_NUM2 + 39'(w_den);
    assign w_tneg = w_num[38];
    assign w_tmag = w_tneg ? (39'(w_dt2) - w_num - 39'd1) : w_num;

    logic                     r_v2;
    logic [dpfh_pkg::T_AW-1:0] r_ta;
    logic [dpfh_pkg::T_DW-1:0] r_td;
    logic                     r_tneg;
    logic [14:0]              r_pl2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ta   <= w_tmag[dpfh_pkg::T_AW-1:0];
        r_td   <= w_dt2;
        r_tneg <= w_tneg;
        r_pl2  <= {r_zero1, r_rh};
    end

    logic                 w_tv;
    logic signed [T_QW:0] w_tterm;
    logic [14:0]          w_tpl;

    dpfh_div #(
        .AW (dpfh_pkg::T_AW),
        .DW (dpfh_pkg::T_DW),
        .QW (T_QW),
        .PW (15)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_a     (r_ta),
        .i_d     (r_td),
        .i_neg   (r_tneg),
        .i_pl    (r_pl2),
        .o_valid (w_tv),
        .o_q     (w_tterm),
        .o_pl    (w_tpl)
    );

    logic                              w_lv;
    logic signed [dpfh_pkg::LN_W-1:0]  w_ln;
    logic [T_QW+1:0]                   w_lpl;

    dpfh_log2 #(
        .PW (T_QW + 2)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tv),
        .i_x     (w_tpl[13:0]),
        .i_pl    ({w_tpl[14], w_tterm}),
        .o_valid (w_lv),
        .o_ln    (w_ln),
        .o_pl    (w_lpl)
    );

    // L, b * L and a - L
    logic signed [23:0] w_l;
    logic signed [24:0] w_dl;
    logic               r_v3;
    logic signed [39:0] r_n2;
    logic [22:0]        r_d2;
    logic               r_zero3;

    assign w_l  = 24'(w_ln) + 24'($signed(w_lpl[T_QW:0]));
    assign w_dl = dpfh_pkg::A_Q16 - 25'(w_l);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= w_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n2    <= 40'(w_l) * dpfh_pkg::B_MUL;
        r_d2    <= w_dl[22:0];
        r_zero3 <= w_lpl[T_QW+1];
    end

    // dew point divider operands
    logic [23:0]        w_ddt2;
    logic signed [41:0] w_dnum;
    logic               w_dneg;
    logic [41:0]        w_dmag;

    assign w_ddt2 = {r_d2, 1'b0};
    assign w_dnum = 42'(r_n2) * 42'sd2 + 42'($signed({1'b0, r_d2}));
    assign w_dneg = w_dnum[41];
    assign w_dmag = w_dneg ? (42'(w_ddt2) - w_dnum - 42'd1) : w_dnum;

    logic                      r_v4;
    logic [dpfh_pkg::D_AW-1:0] r_da;
    logic [dpfh_pkg::D_DW-1:0] r_dd;
    logic                      r_dneg;
    logic                      r_zero4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_da    <= w_dmag[dpfh_pkg::D_AW-1:0];
        r_dd    <= w_ddt2;
        r_dneg  <= w_dneg;
        r_zero4 <= r_zero3;
    end

    logic                 w_dv;
    logic signed [D_QW:0] w_td;
    logic                 w_dzero;

    dpfh_div #(
        .AW (dpfh_pkg::D_AW),
        .DW (dpfh_pkg::D_DW),
        .QW (D_QW),
        .PW (1)
    ) u_ddiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_a     (r_da),
        .i_d     (r_dd),
        .i_neg   (r_dneg),
        .i_pl    (r_zero4),
        .o_valid (w_dv),
        .o_q     (w_td),
        .o_pl    (w_dzero)
    );

    // saturate and flag
    dpfh_pkg::t_out n_out;
    logic           r_strobe;
    dpfh_pkg::t_out r_out;

    always_comb begin
        n_out.valid_res = ~w_dzero;
        if (w_dzero) begin
            n_out.dew_point_centi = dpfh_pkg::TD_MIN;
        end else if (w_td < (D_QW+1)'(dpfh_pkg::TD_MIN)) begin
            n_out.dew_point_centi = dpfh_pkg::TD_MIN;
        end else if (w_td > (D_QW+1)'(dpfh_pkg::TD_MAX)) begin
            n_out.dew_point_centi = dpfh_pkg::TD_MAX;
        end else begin
            n_out.dew_point_centi = w_td[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

### rtl/dpfh_checker.sv
// ----------------------------------------------------------------------------
// dpfh_checker
// Port-level checks on result timing, range and the invalid flag.
// ----------------------------------------------------------------------------
module dpfh_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             o_busy,
    input  dpfh_pkg::t_in    i_in,
    input  logic             o_strobe,
    input  dpfh_pkg::t_out   o_out
);

    localparam int LAT = dpfh_pkg::LATENCY;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] r_cnt;
    logic          w_full;

    assign w_full = (r_cnt == CW'(LAT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (!w_full) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> (o_strobe == $past(i_start && !o_busy, LAT)))
        else $error("result word not one latency after accepted word");

    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_full && o_strobe) |->
            (o_out.valid_res == ($past(i_in.humidity_centi, LAT) != 14'd0)))
        else $error("valid_res does not follow humidity");

    a_invalid_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.valid_res) |-> (o_out.dew_point_centi == dpfh_pkg::TD_MIN))
        else $error("invalid result not at lowest value");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out.dew_point_centi >= dpfh_pkg::TD_MIN &&
                      o_out.dew_point_centi <= dpfh_pkg::TD_MAX))
        else $error("dew point out of range");

endmodule

bind dew_point_from_humidity dpfh_checker u_dpfh_checker (.*);
